// ===== rtl/core/apba_pkg.sv =====
// shared constants, codes and types of the address pool bitmap allocator
// used by every module of the block but apba_ram; depends on nothing

package apba_pkg;

    // largest pool the used map can hold, as log2 of the address count
    localparam int MAX_POOL_LOG2 = 10;

    localparam int ADDR_W    = 32;
    localparam int WORD_W    = 32;
    localparam int BIT_SEL_W = $clog2(WORD_W);
    localparam int MAP_BITS  = 1 << MAX_POOL_LOG2;
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = WORD_AW + BIT_SEL_W;

    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int SIZE_W    = 4;
    localparam int EFF_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam int SIZE_LOG2_MIN   = 2;
    localparam int SIZE_LOG2_RESET = 8;

    localparam int FIFO_DEPTH = 2;

    // request kinds on the input channel
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_LAST   = 2'd3;

    // operations handed from the front end to the back end
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_REPORT = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [SIZE_W-1:0] pool_size_log2;
        logic [ADDR_W-1:0] exclude_first;
        logic [ADDR_W-1:0] exclude_last;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          op;
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [IDX_W-1:0]    last_idx;
        logic                excl_any;
        logic [IDX_W-1:0]    excl_lo;
        logic [IDX_W-1:0]    excl_hi;
        logic [ADDR_W-1:0]   base;
    } cmd_t;

endpackage

// ===== rtl/core/apba_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies

module apba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/apba_front.sv =====
// front end: accepts requests, checks the pool range and builds a command
// depends on apba_pkg

module apba_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [apba_pkg::FUNC_W-1:0]   s_func,
    input  logic [apba_pkg::ADDR_W-1:0]   s_address,
    input  apba_pkg::cfg_t                cfg,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output apba_pkg::cmd_t                cmd
);

    logic                         cmd_valid_reg;
    logic                         cmd_valid_next;
    apba_pkg::cmd_t               cmd_reg;
    apba_pkg::cmd_t               cmd_next;

    logic [apba_pkg::EFF_W-1:0]   eff_log2;
    logic [apba_pkg::ADDR_W-1:0]  mask32;
    logic [apba_pkg::ADDR_W-1:0]  base;
    logic [apba_pkg::ADDR_W-1:0]  top;
    logic [apba_pkg::IDX_W-1:0]   mask_idx;
    logic                         in_pool;
    logic                         accept;

    assign s_ready = !cmd_valid_reg || cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (cfg.pool_size_log2 < apba_pkg::SIZE_W'(apba_pkg::SIZE_LOG2_MIN)) begin
            eff_log2 = apba_pkg::EFF_W'(apba_pkg::SIZE_LOG2_MIN);
        end else if ({1'b0, cfg.pool_size_log2} > apba_pkg::EFF_W'(apba_pkg::MAX_POOL_LOG2)) begin
            eff_log2 = apba_pkg::EFF_W'(apba_pkg::MAX_POOL_LOG2);
        end else begin
            eff_log2 = {1'b0, cfg.pool_size_log2};
        end
    end

    assign mask32   = ~({apba_pkg::ADDR_W{1'b1}} << eff_log2);
    assign base     = cfg.pool_base & ~mask32;
    assign top      = base | mask32;
    assign mask_idx = mask32[apba_pkg::IDX_W-1:0];
    assign in_pool  = (s_address & ~mask32) == base;

    always_comb begin
        cmd_next          = cmd_reg;
        cmd_valid_next    = cmd_valid_reg;
        if (cmd_ready) begin
            cmd_valid_next = 1'b0;
        end
        if (accept) begin
            cmd_valid_next    = 1'b1;
            cmd_next.base     = base;
            cmd_next.index    = s_address[apba_pkg::IDX_W-1:0] & mask_idx;
            cmd_next.last_idx = mask_idx - apba_pkg::IDX_W'(1);
            cmd_next.status   = apba_pkg::STATUS_OK;
            // exclusion range clipped to the pool, as index bounds
            cmd_next.excl_any = !(cfg.exclude_first > cfg.exclude_last)
                                && !(cfg.exclude_last < base)
                                && !(cfg.exclude_first > top);
            cmd_next.excl_lo  = (cfg.exclude_first < base) ? '0
                                : cfg.exclude_first[apba_pkg::IDX_W-1:0] & mask_idx;
            cmd_next.excl_hi  = (cfg.exclude_last > top) ? mask_idx
                                : cfg.exclude_last[apba_pkg::IDX_W-1:0] & mask_idx;
            case (s_func)
                apba_pkg::FUNC_ALLOC: begin
                    cmd_next.op = apba_pkg::OP_ALLOC;
                end
                apba_pkg::FUNC_RELEASE: begin
                    cmd_next.op     = in_pool ? apba_pkg::OP_CLEAR : apba_pkg::OP_REPORT;
                    cmd_next.status = in_pool ? apba_pkg::STATUS_OK
                                              : apba_pkg::STATUS_OUTSIDE;
                end
                apba_pkg::FUNC_MARK: begin
                    cmd_next.op     = in_pool ? apba_pkg::OP_SET : apba_pkg::OP_REPORT;
                    cmd_next.status = in_pool ? apba_pkg::STATUS_OK
                                              : apba_pkg::STATUS_OUTSIDE;
                end
                default: begin
                    cmd_next.op = apba_pkg::OP_REPORT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== rtl/core/apba_fifo.sv =====
// short command queue between the front end and the back end
// depends on apba_pkg

module apba_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  apba_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output apba_pkg::cmd_t out_cmd
);

    localparam int PTR_W = (apba_pkg::FIFO_DEPTH > 1) ? $clog2(apba_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(apba_pkg::FIFO_DEPTH + 1);

    apba_pkg::cmd_t   mem_reg [apba_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(apba_pkg::FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(apba_pkg::FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(apba_pkg::FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/apba_back.sv =====
// back end: runs commands against the used map ram and drives the result beat
// depends on apba_pkg and apba_ram

module apba_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  apba_pkg::cmd_t                  cmd,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [apba_pkg::STATUS_W-1:0]   m_status,
    output logic [apba_pkg::ADDR_W-1:0]     m_granted_address
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    localparam int WORD_W  = apba_pkg::WORD_W;
    localparam int SEL_W   = apba_pkg::BIT_SEL_W;
    localparam int WORD_AW = apba_pkg::WORD_AW;
    localparam int IDX_W   = apba_pkg::IDX_W;

    function automatic logic [SEL_W-1:0] low_pos(input logic [WORD_W-1:0] v);
        logic [SEL_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = SEL_W'(i);
            end
        end
        return pos;
    endfunction

    logic                           state_reg;
    logic                           state_next;
    apba_pkg::cmd_t                 cur_reg;
    apba_pkg::cmd_t                 cur_next;
    logic [WORD_AW-1:0]             word_reg;
    logic [WORD_AW-1:0]             word_next;
    logic                           rd_valid_reg;
    logic [apba_pkg::MAP_WORDS-1:0] word_valid_reg;
    logic [apba_pkg::MAP_WORDS-1:0] word_valid_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [apba_pkg::STATUS_W-1:0]  m_status_reg;
    logic [apba_pkg::STATUS_W-1:0]  m_status_next;
    logic [apba_pkg::ADDR_W-1:0]    m_granted_reg;
    logic [apba_pkg::ADDR_W-1:0]    m_granted_next;

    logic                           rd_en;
    logic [WORD_AW-1:0]             rd_addr;
    logic                           wr_en;
    logic [WORD_W-1:0]              wr_data;
    logic [WORD_W-1:0]              ram_rdata;
    logic [WORD_W-1:0]              data;

    logic [WORD_AW-1:0]             last_word;
    logic [WORD_AW-1:0]             lo_word;
    logic [WORD_AW-1:0]             hi_word;
    logic [WORD_W-1:0]              range_mask;
    logic [WORD_W-1:0]              excl_mask;
    logic [WORD_W-1:0]              free;
    logic [WORD_W-1:0]              cand;
    logic [WORD_W-1:0]              win;
    logic [WORD_W-1:0]              one_hot;
    logic [SEL_W-1:0]               win_pos;

    assign cmd_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);

    apba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (apba_pkg::MAP_WORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (word_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // a word never written reads as all free
    assign data = rd_valid_reg ? ram_rdata : '0;

    assign last_word = cur_reg.last_idx[IDX_W-1:SEL_W];
    assign lo_word   = cur_reg.excl_lo[IDX_W-1:SEL_W];
    assign hi_word   = cur_reg.excl_hi[IDX_W-1:SEL_W];

    // scan window and exclusion window inside the current word
    always_comb begin
        range_mask = '1;
        if (word_reg == '0) begin
            range_mask[0] = 1'b0;
        end
        if (word_reg == last_word) begin
            range_mask = range_mask & ({WORD_W{1'b1}} >> (SEL_W'(WORD_W - 1)
                                       - cur_reg.last_idx[SEL_W-1:0]));
        end
        excl_mask = '0;
        if (cur_reg.excl_any && word_reg >= lo_word && word_reg <= hi_word) begin
            excl_mask = '1;
            if (word_reg == lo_word) begin
                excl_mask = excl_mask & ({WORD_W{1'b1}} << cur_reg.excl_lo[SEL_W-1:0]);
            end
            if (word_reg == hi_word) begin
                excl_mask = excl_mask & ({WORD_W{1'b1}} >> (SEL_W'(WORD_W - 1)
                                         - cur_reg.excl_hi[SEL_W-1:0]));
            end
        end
    end

    assign free    = ~data & range_mask;
    assign cand    = free & ~excl_mask;
    assign win     = cand & (~cand + WORD_W'(1));
    assign win_pos = low_pos(cand);
    assign one_hot = WORD_W'(1) << cur_reg.index[SEL_W-1:0];

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        word_next       = word_reg;
        word_valid_next = word_valid_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_granted_next  = m_granted_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_data         = data;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    cur_next = cmd;
                    if (cmd.op == apba_pkg::OP_REPORT) begin
                        m_valid_next   = 1'b1;
                        m_status_next  = cmd.status;
                        m_granted_next = '0;
                    end else begin
                        rd_en      = 1'b1;
                        rd_addr    = (cmd.op == apba_pkg::OP_ALLOC) ? '0
                                     : cmd.index[IDX_W-1:SEL_W];
                        word_next  = rd_addr;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                wr_en                     = 1'b1;
                word_valid_next[word_reg] = 1'b1;
                case (cur_reg.op)
                    apba_pkg::OP_ALLOC: begin
                        if (cand != '0) begin
                            // winner plus the free excluded bits passed below it
                            wr_data        = data | win | (free & excl_mask & (win - WORD_W'(1)));
                            m_valid_next   = 1'b1;
                            m_status_next  = apba_pkg::STATUS_OK;
                            m_granted_next = cur_reg.base
                                             | apba_pkg::ADDR_W'({word_reg, win_pos});
                            state_next     = ST_IDLE;
                        end else begin
                            wr_data = data | (free & excl_mask);
                            if (word_reg == last_word) begin
                                m_valid_next   = 1'b1;
                                m_status_next  = apba_pkg::STATUS_EXHAUSTED;
                                m_granted_next = '0;
                                state_next     = ST_IDLE;
                            end else begin
                                rd_en     = 1'b1;
                                rd_addr   = word_reg + WORD_AW'(1);
                                word_next = rd_addr;
                            end
                        end
                    end
                    apba_pkg::OP_SET: begin
                        wr_data        = data | one_hot;
                        m_valid_next   = 1'b1;
                        m_status_next  = apba_pkg::STATUS_OK;
                        m_granted_next = '0;
                        state_next     = ST_IDLE;
                    end
                    default: begin
                        wr_data        = data & ~one_hot;
                        m_valid_next   = 1'b1;
                        m_status_next  = apba_pkg::STATUS_OK;
                        m_granted_next = '0;
                        state_next     = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            word_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            word_valid_reg <= word_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        if (rd_en) begin
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
        cur_reg       <= cur_next;
        word_reg      <= word_next;
        m_status_reg  <= m_status_next;
        m_granted_reg <= m_granted_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_granted_address = m_granted_reg;

endmodule

// ===== rtl/core/address_pool_bitmap_allocator.sv =====
// top level of the address pool bitmap allocator: config registers, front end,
// command queue and back end; depends on apba_pkg, apba_front, apba_fifo, apba_back

// First-fit allocator over an aligned pool of 2^pool_size_log2 addresses, the log2
// clamped to 2..10, with one used bit per address held in a 32-bit-wide map ram. A
// request passes a registered front end that checks the pool range, waits in a
// two-entry queue, and is then run by the back end one request at a time. Release
// and mark-used read the map word and write it back. Allocate reads and writes one
// map word per cycle from the word holding index 1 up to the winner; the read port
// of the map ram sets that pace. Reset clears the map at once through per-word
// valid flags, with no clearing pass. Configuration writes are taken at any time
// but must only be made while idle.

module address_pool_bitmap_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [apba_pkg::ADDR_W-1:0]       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [apba_pkg::FUNC_W-1:0]       s_func,
    input  logic [apba_pkg::ADDR_W-1:0]       s_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [apba_pkg::STATUS_W-1:0]     m_status,
    output logic [apba_pkg::ADDR_W-1:0]       m_granted_address
);

    apba_pkg::cfg_t cfg_reg;
    apba_pkg::cfg_t cfg_next;

    logic           front_valid;
    logic           front_ready;
    apba_pkg::cmd_t front_cmd;
    logic           queue_valid;
    logic           queue_ready;
    apba_pkg::cmd_t queue_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                apba_pkg::CFG_POOL_BASE:      cfg_next.pool_base = cfg_data;
                apba_pkg::CFG_POOL_SIZE_LOG2: begin
                    cfg_next.pool_size_log2 = cfg_data[apba_pkg::SIZE_W-1:0];
                end
                apba_pkg::CFG_EXCLUDE_FIRST:  cfg_next.exclude_first = cfg_data;
                apba_pkg::CFG_EXCLUDE_LAST:   cfg_next.exclude_last = cfg_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pool_base      <= '0;
            cfg_reg.pool_size_log2 <= apba_pkg::SIZE_W'(apba_pkg::SIZE_LOG2_RESET);
            cfg_reg.exclude_first  <= '0;
            cfg_reg.exclude_last   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    apba_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_address (s_address),
        .cfg       (cfg_reg),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    apba_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    apba_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (queue_valid),
        .cmd_ready         (queue_ready),
        .cmd               (queue_cmd),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address)
    );

endmodule

// ===== test/address_pool_bitmap_allocator_test.sv =====
// self-checking testbench for address_pool_bitmap_allocator: directed table, then random phases
// keeps its own used-bit map and register copy to predict every result beat
// depends on apba_pkg and the allocator rtl only

module address_pool_bitmap_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import apba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 40;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_ITEMS    = 117;

    typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

    // code is the request kind or the register index, value the address or register data
    typedef struct packed {
        step_kind_t          kind;
        logic [1:0]          code;
        logic [ADDR_W-1:0]   value;
        logic                typed;
        logic [STATUS_W-1:0] want_status;
        logic [ADDR_W-1:0]   want_grant;
    } plan_step_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   grant;
    } pool_result_t;

    localparam int PLAN_LEN = 39;
    localparam plan_step_t PLAN [PLAN_LEN] = '{
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b1, STATUS_OK,      32'h1},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b1, STATUS_OK,      32'h2},
        '{STEP_REQUEST, FUNC_RELEASE,       32'hFFFF_FFFF, 1'b1, STATUS_OUTSIDE, 32'h0},
        '{STEP_REQUEST, FUNC_MARK,          32'h0000_0100, 1'b1, STATUS_OUTSIDE, 32'h0},
        '{STEP_REQUEST, FUNC_UNKNOWN,       32'hA5A5_5A5A, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_MARK,          32'h0000_0003, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_0001, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        // network and broadcast bits can be touched directly
        '{STEP_REQUEST, FUNC_MARK,          32'h0000_0000, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_00FF, 1'b1, STATUS_OK,      32'h0},
        // unaligned top base, oversized log2, exclusion inside the pool
        '{STEP_CONFIG,  CFG_POOL_BASE,      32'hFFFF_FFFF, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_POOL_SIZE_LOG2, 32'h0000_000F, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_FIRST,  32'hFFFF_FC05, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_LAST,   32'hFFFF_FC08, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_MARK,          32'hFFFF_FFFF, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_0000, 1'b1, STATUS_OUTSIDE, 32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'hFFFF_FBFF, 1'b1, STATUS_OUTSIDE, 32'h0},
        // undersized log2 and an empty exclusion range
        '{STEP_CONFIG,  CFG_POOL_BASE,      32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_POOL_SIZE_LOG2, 32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_FIRST,  32'h0000_0005, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_LAST,   32'h0000_0001, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_0002, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        // whole address space excluded: every free bit gets burned
        '{STEP_CONFIG,  CFG_POOL_SIZE_LOG2, 32'h0000_000A, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_FIRST,  32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_LAST,   32'hFFFF_FFFF, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        // a free broadcast bit is still never granted
        '{STEP_CONFIG,  CFG_POOL_SIZE_LOG2, 32'h0000_0004, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_FIRST,  32'h0000_0001, 1'b0, STATUS_OK,      32'h0},
        '{STEP_CONFIG,  CFG_EXCLUDE_LAST,   32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_000F, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_RELEASE,       32'h0000_0007, 1'b1, STATUS_OK,      32'h0},
        '{STEP_REQUEST, FUNC_ALLOC,         32'h0000_0000, 1'b0, STATUS_OK,      32'h0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func = '0;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [ADDR_W-1:0]     m_granted_address;

    // predictor state
    bit [MAP_BITS-1:0]     used_bits = '0;
    logic [ADDR_W-1:0]     pool_base_reg = '0;
    logic [SIZE_W-1:0]     pool_size_reg = SIZE_W'(SIZE_LOG2_RESET);
    logic [ADDR_W-1:0]     excl_first_reg = '0;
    logic [ADDR_W-1:0]     excl_last_reg = '0;

    pool_result_t          awaited_results[$];
    logic [ADDR_W-1:0]     recent_grants[$];

    int sender_idle_pct = 20;
    int receiver_stall_pct = 61;
    int errors = 0;
    int idle_cycles = 0;
    int n_requests = 0;
    int n_granted = 0;
    int n_exhausted = 0;
    int n_outside = 0;
    int n_reg_writes = 0;

    address_pool_bitmap_allocator dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_address         (s_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_granted_address (m_granted_address)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic int unsigned pool_log2();
        if (pool_size_reg < SIZE_LOG2_MIN) return SIZE_LOG2_MIN;
        if (pool_size_reg > MAX_POOL_LOG2) return MAX_POOL_LOG2;
        return 32'(pool_size_reg);
    endfunction

    function automatic logic [ADDR_W-1:0] pool_mask();
        return (32'd1 << pool_log2()) - 32'd1;
    endfunction

    // first-fit scan from index 1, skipping broadcast; free excluded bits passed get set
    function automatic void pool_outcome(input logic [FUNC_W-1:0] func,
                                         input logic [ADDR_W-1:0] addr,
                                         output logic [STATUS_W-1:0] status,
                                         output logic [ADDR_W-1:0] grant);
        logic [ADDR_W-1:0] span_mask;
        logic [ADDR_W-1:0] pool_lo;
        logic [ADDR_W-1:0] cand;
        bit found;
        span_mask = pool_mask();
        pool_lo = pool_base_reg & ~span_mask;
        status = STATUS_OK;
        grant = '0;
        found = 1'b0;
        if (func == FUNC_ALLOC) begin
            for (int unsigned i = 1; i < span_mask; i++) begin
                if (!found && !used_bits[i]) begin
                    cand = pool_lo + i;
                    used_bits[i] = 1'b1;
                    if (cand < excl_first_reg || cand > excl_last_reg) begin
                        grant = cand;
                        found = 1'b1;
                    end
                end
            end
            if (!found) status = STATUS_EXHAUSTED;
        end else if (func == FUNC_RELEASE || func == FUNC_MARK) begin
            if ((addr & ~span_mask) != pool_lo) status = STATUS_OUTSIDE;
            else used_bits[addr & span_mask] = (func == FUNC_MARK);
        end
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_POOL_BASE:      pool_base_reg = data;
            CFG_POOL_SIZE_LOG2: pool_size_reg = data[SIZE_W-1:0];
            CFG_EXCLUDE_FIRST:  excl_first_reg = data;
            CFG_EXCLUDE_LAST:   excl_last_reg = data;
            default: ;
        endcase
        n_reg_writes++;
        @(posedge aclk);
    endtask

    // returns at the accepting edge with valid still high, so a follow-on beat can go back to back
    task automatic put_request(input logic [FUNC_W-1:0] func,
                               input logic [ADDR_W-1:0] addr,
                               input logic typed,
                               input logic [STATUS_W-1:0] want_status,
                               input logic [ADDR_W-1:0] want_grant);
        pool_result_t outcome;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
        pool_outcome(func, addr, outcome.status, outcome.grant);
        n_requests++;
        if (outcome.status == STATUS_EXHAUSTED) n_exhausted++;
        if (outcome.status == STATUS_OUTSIDE) n_outside++;
        if (func == FUNC_ALLOC && outcome.status == STATUS_OK) begin
            n_granted++;
            recent_grants.push_back(outcome.grant);
        end
        if (typed) begin
            outcome.status = want_status;
            outcome.grant  = want_grant;
        end
        awaited_results.push_back(outcome);
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_random_setting();
        logic [ADDR_W-1:0] span_mask;
        logic [ADDR_W-1:0] pool_lo;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [SIZE_W-1:0] size_log2;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) size_log2 = SIZE_W'($urandom_range(5, 2));
        else if (pick < 80) size_log2 = SIZE_W'($urandom_range(9, 6));
        else if (pick < 90) size_log2 = SIZE_W'(MAX_POOL_LOG2);
        else size_log2 = SIZE_W'($urandom_range(15, 0));
        write_register(CFG_POOL_SIZE_LOG2, ADDR_W'(size_log2));
        write_register(CFG_POOL_BASE, $urandom);
        span_mask = pool_mask();
        pool_lo = pool_base_reg & ~span_mask;
        pick = $urandom_range(99);
        if (pick < 45) begin
            lo = pool_lo + $urandom_range(span_mask, 0);
            hi = lo + $urandom_range(span_mask >> 2, 0);
        end else if (pick < 65) begin
            // empty range
            hi = pool_lo + $urandom_range(span_mask, 0);
            lo = hi + 32'd1;
        end else if (pick < 75) begin
            lo = pool_lo;
            hi = pool_lo + span_mask;
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
        write_register(CFG_EXCLUDE_FIRST, lo);
        write_register(CFG_EXCLUDE_LAST, hi);
    endtask

    task automatic run_random_phase(input int count);
        logic [ADDR_W-1:0] span_mask;
        logic [ADDR_W-1:0] pool_lo;
        logic [ADDR_W-1:0] addr;
        logic [FUNC_W-1:0] func;
        int pick;
        int slot;
        span_mask = pool_mask();
        pool_lo = pool_base_reg & ~span_mask;
        repeat (count) begin
            pick = $urandom_range(99);
            addr = pool_lo | ($urandom & span_mask);
            if (pick < 40) begin
                func = FUNC_ALLOC;
                addr = $urandom;
            end else if (pick < 75) begin
                func = FUNC_RELEASE;
                // free something that was really handed out, half of the time
                if (recent_grants.size() != 0 && $urandom_range(1) == 1) begin
                    slot = $urandom_range(recent_grants.size() - 1, 0);
                    addr = recent_grants[slot];
                    recent_grants.delete(slot);
                end
            end else if (pick < 90) begin
                func = FUNC_MARK;
            end else if (pick < 97) begin
                func = ($urandom_range(1) == 1) ? FUNC_RELEASE : FUNC_MARK;
                case ($urandom_range(2, 0))
                    0: addr = pool_lo - 32'd1;
                    1: addr = pool_lo + span_mask + 32'd1;
                    default: addr = $urandom;
                endcase
            end else begin
                func = FUNC_UNKNOWN;
                addr = $urandom;
            end
            put_request(func, addr, 1'b0, STATUS_OK, '0);
        end
    endtask

    always @(posedge aclk) begin
        pool_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got status %0d grant %h",
                         $time, m_status, m_granted_address);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_granted_address !== want.grant) begin
                    $display("%0t: granted address mismatch, expected %h, got %h",
                             $time, want.grant, m_granted_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, awaited_results.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            if (PLAN[r].kind == STEP_CONFIG) begin
                wait_for_idle();
                write_register(PLAN[r].code, PLAN[r].value);
            end else begin
                put_request(PLAN[r].code, PLAN[r].value, PLAN[r].typed,
                            PLAN[r].want_status, PLAN[r].want_grant);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_for_idle();
            if (p == RANDOM_PHASES / 3) begin
                sender_idle_pct = 61;
                receiver_stall_pct = 20;
            end else if (p == 2 * RANDOM_PHASES / 3) begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            apply_random_setting();
            recent_grants.delete();
            run_random_phase(PHASE_ITEMS);
        end
        wait_for_idle();

        $display("%0d requests over %0d register writes: %0d granted, %0d exhausted, %0d outside",
                 n_requests, n_reg_writes, n_granted, n_exhausted, n_outside);
        $display("idle mixes: sender-light, receiver-light and back to back; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
